// ----- design/pab_pkg.sv -----
// Shared types and constants for the planar array beamformer.
// No dependencies; imported by every module of the block.
`default_nettype none
package pab_pkg;

	// Maximum numbers of array elements along x and y unless overridden.
	localparam int MAX_COLS_DEF = 8;
	localparam int MAX_ROWS_DEF = 8;

	// Sample and accumulator widths.
	localparam int SAMPLE_W = 16;
	localparam int ACC_W    = 40;

	// Configuration port.
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_COLS  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROWS  = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_THETA = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PHI   = 8'd3;

	// Reset values of the registers.
	localparam logic [3:0]  COLS_RST  = 4'd4;
	localparam logic [3:0]  ROWS_RST  = 4'd4;
	localparam logic [15:0] THETA_RST = 16'h4000;
	localparam logic [15:0] PHI_RST   = 16'h0000;

	// Fixed-point trigonometry constants (Q30 radians and Q15 rounding).
	localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
	localparam logic [31:0] Q30_ONE      = 32'h4000_0000;
	localparam logic [15:0] QUARTER_TURN = 16'h4000;
	localparam int          ROUND_Q15    = 16384;

	// Request to and answer from the shared sine unit.
	typedef struct packed {
		logic        start;
		logic [15:0] angle;
	} trig_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] value;
	} trig_rsp_t;

endpackage
`default_nettype wire

// ----- design/planar_array_beamformer.sv -----
// Delay-and-sum beamformer for a planar array. Complex Q1.15 samples enter one word
// per clock on s_t* while not held off, cols*rows per snapshot in row-major order; each
// is multiplied by a steering weight from a MAX_COLS*MAX_ROWS-entry (64 by default)
// weight memory and accumulated, and the snapshot average leaves as one word on m_t*.
// Within a snapshot one word is taken every cycle unless a weight build runs or
// cfg_valid is high (read, multiply, accumulate in three stages). The last word of a
// snapshot is held off until the previous result has been taken; each result is ready
// after a 26-step serial division by the element count. After reset and after every
// register write the weight memory is rebuilt and no word is taken meanwhile; the build
// runs through the single shared sine unit, one sine at a time.
// Depends on pab_pkg, pab_trig, pab_wgen and pab_core.
`default_nettype none
module planar_array_beamformer #(
	parameter int MAX_COLS = pab_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = pab_pkg::MAX_ROWS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [31:0]                         s_tdata,   // sample_re[15:0], sample_im[31:16]
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [31:0]                        m_tdata,   // beam_re[15:0], beam_im[31:16]
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [pab_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire [pab_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pab_pkg::*;

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(DEPTH + 1);
	localparam int ECW   = $clog2(MAX_COLS + 1);
	localparam int ERW   = $clog2(MAX_ROWS + 1);

	logic [3:0]     cols_q;
	logic [3:0]     rows_q;
	logic [15:0]    theta_q;
	logic [15:0]    phi_q;

	logic           cfg_we;
	logic           size_we;
	logic           rebuild;
	logic [ECW-1:0] nc;
	logic [ERW-1:0] nr;
	logic [NW-1:0]  n_eff;
	logic           build_busy;
	trig_req_t      trig_req;
	trig_rsp_t      trig_rsp;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [31:0]    wr_data;

	// Register writes are taken while no weight build runs.
	assign cfg_ready = !build_busy;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign size_we   = cfg_we && ((cfg_index == REG_COLS) || (cfg_index == REG_ROWS));
	assign rebuild   = size_we || (cfg_we && ((cfg_index == REG_THETA) ||
	                                           (cfg_index == REG_PHI)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= COLS_RST;
			rows_q  <= ROWS_RST;
			theta_q <= THETA_RST;
			phi_q   <= PHI_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLS:  cols_q  <= cfg_data[3:0];
				REG_ROWS:  rows_q  <= cfg_data[3:0];
				REG_THETA: theta_q <= cfg_data;
				REG_PHI:   phi_q   <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Sizes of zero act as one, sizes above the maximum act as the maximum.
	always_comb begin
		if (cols_q == 4'd0) begin
			nc = ECW'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			nc = ECW'(MAX_COLS);
		end else begin
			nc = ECW'(cols_q);
		end
		if (rows_q == 4'd0) begin
			nr = ERW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			nr = ERW'(MAX_ROWS);
		end else begin
			nr = ERW'(rows_q);
		end
		n_eff = NW'(32'(nc) * 32'(nr));
	end

	pab_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (trig_req),
		.rsp    (trig_rsp)
	);

	pab_wgen #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_wgen (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rebuild),
		.theta    (theta_q),
		.phi      (phi_q),
		.nc       (nc),
		.nr       (nr),
		.trig_req (trig_req),
		.trig_rsp (trig_rsp),
		.busy     (build_busy),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	pab_core #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (build_busy || cfg_valid),
		.clear    (size_we),
		.n_eff    (n_eff),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

// ----- design/pab_trig.sv -----
// Iterative Q1.15 sine of a 16-bit binary angle (Taylor series in Q30).
// Uses one shared 32x32 multiplier, also for the reciprocal divisions by the series
// constants; needs pab_pkg.
`default_nettype none
module pab_trig (
	input  wire                clk,
	input  wire                arst_n,
	input  pab_pkg::trig_req_t req,
	output pab_pkg::trig_rsp_t rsp
);
	import pab_pkg::*;

	typedef enum logic [3:0] {
		T_IDLE, T_MY, T_LY, T_MY2, T_LY2, T_MD, T_LD, T_MT, T_LT, T_MR, T_LR
	} state_t;

	// Reciprocals for the series denominators. Each step divides 72, 42, 20 and 6
	// as a small shift followed by an exact division by 9, 21, 5 and 3.
	localparam logic [31:0] RECIP_9  = 32'd954437177;
	localparam logic [31:0] RECIP_21 = 32'd3272356036;
	localparam logic [31:0] RECIP_5  = 32'd3435973837;
	localparam logic [31:0] RECIP_3  = 32'd2863311531;

	state_t       state_q;
	logic [1:0]   quad_q;
	logic [14:0]  fe_q;
	logic [31:0]  y_q;
	logic [31:0]  y2_q;
	logic [31:0]  t_q;
	logic [31:0]  div_q;
	logic [1:0]   stage_q;
	logic [63:0]  prod_q;
	trig_rsp_t    rsp_q;

	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [14:0]  fe_in;
	logic [31:0]  div_in;
	logic [31:0]  recip;
	logic [31:0]  quo;
	logic [34:0]  r_sum;
	logic [19:0]  r_mag;
	logic [15:0]  r_cap;

	// Quarter-wave fraction, mirrored in odd quadrants.
	assign fe_in = req.angle[14] ? (15'h4000 - {1'b0, req.angle[13:0]})
	                             : {1'b0, req.angle[13:0]};

	// Pre-shift, reciprocal and quotient position for the current series step.
	always_comb begin
		case (stage_q)
			2'd0: begin
				div_in = {3'd0, div_q[31:3]};
				recip  = RECIP_9;
				quo    = {1'b0, prod_q[63:33]};
			end
			2'd1: begin
				div_in = {1'b0, div_q[31:1]};
				recip  = RECIP_21;
				quo    = {4'd0, prod_q[63:36]};
			end
			2'd2: begin
				div_in = {2'd0, div_q[31:2]};
				recip  = RECIP_5;
				quo    = {2'd0, prod_q[63:34]};
			end
			default: begin
				div_in = {1'b0, div_q[31:1]};
				recip  = RECIP_3;
				quo    = {1'b0, prod_q[63:33]};
			end
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			T_MY:    begin mul_a = {17'd0, fe_q}; mul_b = HALF_PI_Q30; end
			T_MY2:   begin mul_a = y_q;    mul_b = y_q; end
			T_MD:    begin mul_a = div_in; mul_b = recip; end
			T_MT:    begin mul_a = y2_q;   mul_b = t_q; end
			T_MR:    begin mul_a = y_q;    mul_b = t_q; end
			default: begin mul_a = y_q;    mul_b = y_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Final rounding to Q1.15 with the cap at full scale.
	always_comb begin
		r_sum = {1'b0, prod_q[63:30]} + 35'(ROUND_Q15);
		r_mag = r_sum[34:15];
		r_cap = (r_mag > 20'd32767) ? 16'h7FFF : r_mag[15:0];
	end

	// Sequencer of the series evaluation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			quad_q  <= '0;
			fe_q    <= '0;
			y_q     <= '0;
			y2_q    <= '0;
			t_q     <= '0;
			div_q   <= '0;
			stage_q <= '0;
			rsp_q   <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (req.start) begin
						quad_q  <= req.angle[15:14];
						fe_q    <= fe_in;
						state_q <= T_MY;
					end
				end
				T_MY:  state_q <= T_LY;
				T_LY: begin
					y_q     <= prod_q[45:14];
					state_q <= T_MY2;
				end
				T_MY2: state_q <= T_LY2;
				T_LY2: begin
					y2_q    <= prod_q[61:30];
					div_q   <= prod_q[61:30];
					stage_q <= '0;
					state_q <= T_MD;
				end
				T_MD:  state_q <= T_LD;
				T_LD: begin
					t_q     <= Q30_ONE - quo;
					state_q <= (stage_q == 2'd3) ? T_MR : T_MT;
				end
				T_MT:  state_q <= T_LT;
				T_LT: begin
					div_q   <= prod_q[61:30];
					stage_q <= stage_q + 2'd1;
					state_q <= T_MD;
				end
				T_MR:  state_q <= T_LR;
				T_LR: begin
					rsp_q.done  <= 1'b1;
					rsp_q.value <= quad_q[1] ? (~r_cap + 16'd1) : r_cap;
					state_q     <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

// ----- design/pab_wgen.sv -----
// Steering weight generator: walks the array row-major and writes cos/sin weights.
// Drives the shared sine unit pab_trig; needs pab_pkg.
`default_nettype none
module pab_wgen #(
	parameter int MAX_COLS = pab_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = pab_pkg::MAX_ROWS_DEF,
	localparam int DEPTH = MAX_COLS * MAX_ROWS,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int ECW   = $clog2(MAX_COLS + 1),
	localparam int ERW   = $clog2(MAX_ROWS + 1)
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire [15:0]         theta,
	input  wire [15:0]         phi,
	input  wire [ECW-1:0]      nc,
	input  wire [ERW-1:0]      nr,
	output pab_pkg::trig_req_t trig_req,
	input  pab_pkg::trig_rsp_t trig_rsp,
	output logic               busy,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [31:0]        wr_data
);
	import pab_pkg::*;

	localparam int S_W = 16 + ((ECW > ERW) ? ECW : ERW) + 2;

	typedef enum logic [3:0] {
		B_IDLE, B_CT, B_CP, B_SP, B_S, B_P, B_WR, B_WI
	} state_t;

	state_t                 state_q;
	logic                   issued_q;
	logic signed [15:0]     ct_q;
	logic signed [15:0]     cp_q;
	logic signed [15:0]     sp_q;
	logic [15:0]            wr_q;
	logic signed [S_W-1:0]  s_q;
	logic [31:0]            p_q;
	logic [ECW-1:0]         i_q;
	logic [ERW-1:0]         j_q;
	logic [AW-1:0]          addr_q;
	logic                   wr_en_q;
	logic [AW-1:0]          wr_addr_q;
	logic [31:0]            wr_data_q;

	logic                   trig_state;
	logic signed [S_W-1:0]  iw;
	logic signed [S_W-1:0]  jw;
	logic signed [31:0]     ct32;
	logic signed [31:0]     s32;
	logic [15:0]            ph;

	assign ph = p_q[30:15];
	assign iw = S_W'(signed'({1'b0, i_q}));
	assign jw = S_W'(signed'({1'b0, j_q}));
	assign ct32 = 32'(ct_q);
	assign s32  = 32'(s_q);

	// Angle handed to the sine unit in each phase of the walk.
	always_comb begin
		trig_state = 1'b1;
		case (state_q)
			B_CT:    trig_req.angle = theta + QUARTER_TURN;
			B_CP:    trig_req.angle = phi + QUARTER_TURN;
			B_SP:    trig_req.angle = phi;
			B_WR:    trig_req.angle = ph + QUARTER_TURN;
			B_WI:    trig_req.angle = ph;
			default: begin
				trig_req.angle = ph;
				trig_state     = 1'b0;
			end
		endcase
		trig_req.start = trig_state && !issued_q;
	end

	// Walk over the elements; reset starts a build of the reset configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CT;
			issued_q  <= 1'b0;
			ct_q      <= '0;
			cp_q      <= '0;
			sp_q      <= '0;
			wr_q      <= '0;
			s_q       <= '0;
			p_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			addr_q    <= '0;
			wr_en_q   <= 1'b0;
			wr_addr_q <= '0;
			wr_data_q <= '0;
		end else begin
			wr_en_q <= 1'b0;
			if (trig_req.start) begin
				issued_q <= 1'b1;
			end
			if (trig_rsp.done) begin
				issued_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (start) begin
						state_q <= B_CT;
					end
				end
				B_CT: begin
					if (trig_rsp.done) begin
						ct_q    <= trig_rsp.value;
						state_q <= B_CP;
					end
				end
				B_CP: begin
					if (trig_rsp.done) begin
						cp_q    <= trig_rsp.value;
						state_q <= B_SP;
					end
				end
				B_SP: begin
					if (trig_rsp.done) begin
						sp_q    <= trig_rsp.value;
						i_q     <= '0;
						j_q     <= '0;
						addr_q  <= '0;
						state_q <= B_S;
					end
				end
				B_S: begin
					s_q     <= iw * S_W'(cp_q) + jw * S_W'(sp_q);
					state_q <= B_P;
				end
				B_P: begin
					p_q     <= ct32 * s32 + 32'(ROUND_Q15);
					state_q <= B_WR;
				end
				B_WR: begin
					if (trig_rsp.done) begin
						wr_q    <= trig_rsp.value;
						state_q <= B_WI;
					end
				end
				B_WI: begin
					if (trig_rsp.done) begin
						wr_en_q   <= 1'b1;
						wr_addr_q <= addr_q;
						wr_data_q <= {trig_rsp.value, wr_q};
						addr_q    <= addr_q + 1'b1;
						if (j_q == nr - 1'b1) begin
							j_q <= '0;
							if (i_q == nc - 1'b1) begin
								state_q <= B_IDLE;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= B_S;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= B_S;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign busy    = (state_q != B_IDLE) || wr_en_q;
	assign wr_en   = wr_en_q;
	assign wr_addr = wr_addr_q;
	assign wr_data = wr_data_q;

endmodule
`default_nettype wire

// ----- design/pab_fin.sv -----
// Snapshot normalizer: divides both sums by count*2^15, rounds, saturates to Q1.15.
// Two-lane bit-serial divider with an output register; needs pab_pkg.
`default_nettype none
module pab_fin #(
	parameter int NW = 7
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire signed [pab_pkg::ACC_W-1:0]  acc_re,
	input  wire signed [pab_pkg::ACC_W-1:0]  acc_im,
	input  wire [NW-1:0]                     n,
	output logic                             busy,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [31:0]                      m_tdata
);
	import pab_pkg::*;

	localparam int UW = ACC_W - 14;
	localparam int CW = $clog2(UW);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_SAT, F_OUT} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic [UW-1:0]     u_q   [2];
	logic [NW-1:0]     rem_q [2];
	logic              neg_q [2];
	logic [15:0]       res_q [2];

	logic [ACC_W-1:0]  acc_in [2];
	logic [ACC_W-1:0]  mag    [2];
	logic [ACC_W:0]    biased [2];
	logic [NW:0]       rs     [2];
	logic [NW:0]       rs_sub [2];
	logic              ge     [2];

	assign acc_in[0] = acc_re;
	assign acc_in[1] = acc_im;

	// Magnitude plus half the divisor, pre-shifted by 2^15; then a serial step.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mag[l]    = acc_in[l][ACC_W-1] ? (~acc_in[l] + 1'b1) : acc_in[l];
			biased[l] = {1'b0, mag[l]} + ((ACC_W+1)'(n) << 14);
			rs[l]     = {rem_q[l], u_q[l][UW-1]};
			rs_sub[l] = rs[l] - {1'b0, n};
			ge[l]     = rs[l] >= {1'b0, n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			for (int l = 0; l < 2; l++) begin
				u_q[l]   <= '0;
				rem_q[l] <= '0;
				neg_q[l] <= 1'b0;
				res_q[l] <= '0;
			end
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						for (int l = 0; l < 2; l++) begin
							u_q[l]   <= biased[l][ACC_W:15];
							rem_q[l] <= '0;
							neg_q[l] <= acc_in[l][ACC_W-1];
						end
						cnt_q   <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					for (int l = 0; l < 2; l++) begin
						u_q[l]   <= {u_q[l][UW-2:0], ge[l]};
						rem_q[l] <= ge[l] ? rs_sub[l][NW-1:0] : rs[l][NW-1:0];
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(UW - 1)) begin
						state_q <= F_SAT;
					end
				end
				F_SAT: begin
					// Quotient now sits in u_q; clamp to the Q1.15 range.
					for (int l = 0; l < 2; l++) begin
						if (neg_q[l]) begin
							res_q[l] <= (u_q[l] > UW'(32768)) ? 16'h8000
							                                  : (~u_q[l][15:0] + 16'd1);
						end else begin
							res_q[l] <= (u_q[l] > UW'(32767)) ? 16'h7FFF : u_q[l][15:0];
						end
					end
					state_q <= F_OUT;
				end
				F_OUT: begin
					if (m_tready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign busy     = (state_q != F_IDLE);
	assign m_tvalid = (state_q == F_OUT);
	assign m_tdata  = {res_q[1], res_q[0]};

endmodule
`default_nettype wire

// ----- design/pab_core.sv -----
// Sample path: weight memory, complex multiply, accumulation and snapshot control.
// Instantiates pab_fin for the final division; needs pab_pkg.
`default_nettype none
module pab_core #(
	parameter int MAX_COLS = pab_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = pab_pkg::MAX_ROWS_DEF,
	localparam int DEPTH = MAX_COLS * MAX_ROWS,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW    = $clog2(DEPTH + 1)
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           hold,
	input  wire           clear,
	input  wire [NW-1:0]  n_eff,
	input  wire           wr_en,
	input  wire [AW-1:0]  wr_addr,
	input  wire [31:0]    wr_data,
	input  wire           s_tvalid,
	output logic          s_tready,
	input  wire [31:0]    s_tdata,
	output logic          m_tvalid,
	input  wire           m_tready,
	output logic [31:0]   m_tdata
);
	import pab_pkg::*;

	logic [31:0]              wmem [DEPTH];

	logic [NW-1:0]            count_q;
	logic                     pend_q;
	logic                     v_s1;
	logic                     last_s1;
	logic [31:0]              smp_s1;
	logic [31:0]              w_s1;
	logic                     v_s2;
	logic                     last_s2;
	logic signed [31:0]       p_rr_s2;
	logic signed [31:0]       p_ii_s2;
	logic signed [31:0]       p_ri_s2;
	logic signed [31:0]       p_ir_s2;
	logic signed [ACC_W-1:0]  acc_re_q;
	logic signed [ACC_W-1:0]  acc_im_q;

	logic                     accept;
	logic                     last_now;
	logic signed [15:0]       sr;
	logic signed [15:0]       si;
	logic signed [15:0]       wr;
	logic signed [15:0]       wi;
	logic signed [ACC_W-1:0]  sum_re;
	logic signed [ACC_W-1:0]  sum_im;
	logic                     fin_start;
	logic                     fin_busy;

	// The last word of a snapshot waits until the previous result has left.
	assign last_now = ({1'b0, count_q} + 1'b1) >= {1'b0, n_eff};
	assign s_tready = !hold && !(last_now && pend_q);
	assign accept   = s_tvalid && s_tready;

	// Weight memory: one write port from the generator, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wmem[wr_addr] <= wr_data;
		end
		if (accept) begin
			w_s1   <= wmem[count_q[AW-1:0]];
			smp_s1 <= s_tdata;
		end
	end

	// Complex product, stage two.
	assign sr = smp_s1[15:0];
	assign si = smp_s1[31:16];
	assign wr = w_s1[15:0];
	assign wi = w_s1[31:16];

	always_ff @(posedge clk) begin
		p_rr_s2 <= sr * wr;
		p_ii_s2 <= si * wi;
		p_ri_s2 <= sr * wi;
		p_ir_s2 <= si * wr;
	end

	assign sum_re = acc_re_q + ACC_W'(p_rr_s2) - ACC_W'(p_ii_s2);
	assign sum_im = acc_im_q + ACC_W'(p_ri_s2) + ACC_W'(p_ir_s2);
	assign fin_start = v_s2 && last_s2;

	// Element counter, pipeline valids and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pend_q   <= 1'b0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else begin
			v_s1    <= accept;
			last_s1 <= accept && last_now;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (m_tvalid && m_tready) begin
				pend_q <= 1'b0;
			end
			if (accept && last_now) begin
				pend_q <= 1'b1;
			end
			if (clear) begin
				count_q  <= '0;
				acc_re_q <= '0;
				acc_im_q <= '0;
			end else begin
				if (accept) begin
					count_q <= last_now ? '0 : count_q + 1'b1;
				end
				if (v_s2) begin
					acc_re_q <= last_s2 ? '0 : sum_re;
					acc_im_q <= last_s2 ? '0 : sum_im;
				end
			end
		end
	end

	pab_fin #(
		.NW(NW)
	) u_fin (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (fin_start),
		.acc_re   (sum_re),
		.acc_im   (sum_im),
		.n        (n_eff),
		.busy     (fin_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef ASSERT_OFF
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < n_eff)
		else $error("element count reached snapshot size");
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		fin_start |-> !fin_busy)
		else $error("snapshot finished while normalizer busy");
	a_out_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q)
		else $error("result shown without pending snapshot");
	a_last_pending: assert property (@(posedge clk) disable iff (!arst_n)
		fin_start |-> pend_q)
		else $error("last element in flight without pending flag");
`endif

endmodule
`default_nettype wire
